/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define FUC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Clocked assertion, active through reset as well.
`define FUC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

/* rtl/fuc_pkg.sv */
// Shared types and constants for the float ULP compare block.
package fuc_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned TOL_W  = 31;
  localparam int unsigned ADDR_W = 3;

  localparam logic [31:0] SIGN_BIT   = 32'h8000_0000;
  localparam logic [30:0] MIN_NORMAL = 31'h0080_0000;
  localparam logic [31:0] SQ_POS_OFS = 32'h7F80_0001;
  localparam logic [31:0] SQ_NEG_OFS = 32'h807F_FFFF;
  localparam logic [7:0]  EXP_ALL    = 8'hFF;

  localparam logic [TOL_W-1:0] TOL_RESET = 31'd2;

  // Register index, taken from paddr[2].
  typedef enum logic {
    REG_TOL = 1'b0,
    REG_SQZ = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [TOL_W-1:0] tol;
    logic             squeeze;
  } fuc_cfg_t;

endpackage

/* rtl/fuc_if.sv */
// Valid/ready stream interfaces for compare requests and results.
interface fuc_in_if;
  logic                      valid;
  logic                      ready;
  logic [fuc_pkg::WORD_W-1:0] expected_word;
  logic [fuc_pkg::WORD_W-1:0] actual_word;

  modport source (output valid, output expected_word, output actual_word, input ready);
  modport sink   (input valid, input expected_word, input actual_word, output ready);
endinterface

interface fuc_out_if;
  logic valid;
  logic ready;
  logic values_differ;

  modport source (output valid, output values_differ, input ready);
  modport sink   (input valid, input values_differ, output ready);
endinterface

/* rtl/fuc_cfg_regs.sv */
// APB-style configuration registers: tolerance and denormal squeeze mode.
module fuc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fuc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output fuc_pkg::fuc_cfg_t           cfg
);

  logic [fuc_pkg::TOL_W-1:0] tol_r;
  logic [fuc_pkg::TOL_W-1:0] tol_nxt;
  logic                      sqz_r;
  logic                      sqz_nxt;
  logic                      wr_en;
  fuc_pkg::reg_idx_t         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = fuc_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    tol_nxt = tol_r;
    sqz_nxt = sqz_r;
    if (wr_en) begin
      case (idx)
        fuc_pkg::REG_TOL: tol_nxt = pwdata[fuc_pkg::TOL_W-1:0];
        fuc_pkg::REG_SQZ: sqz_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fuc_pkg::REG_TOL: prdata = {1'b0, tol_r};
      fuc_pkg::REG_SQZ: prdata = {31'd0, sqz_r};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= fuc_pkg::TOL_RESET;
      sqz_r <= 1'b0;
    end else begin
      tol_r <= tol_nxt;
      sqz_r <= sqz_nxt;
    end
  end

  assign cfg.tol     = tol_r;
  assign cfg.squeeze = sqz_r;

endmodule

/* rtl/fuc_datapath.sv */
// Three-register compare pipeline: input words, ordered values, result.
module fuc_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fuc_pkg::fuc_cfg_t           cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fuc_pkg::WORD_W-1:0]  in_expected,
  input  logic [fuc_pkg::WORD_W-1:0]  in_actual,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_differ
);

  function automatic logic [31:0] order_map(input logic [31:0] w, input logic sq);
    logic [30:0] mag;
    logic [31:0] res;
    mag = w[30:0];
    if (sq) begin
      if (mag < fuc_pkg::MIN_NORMAL) res = fuc_pkg::SIGN_BIT;
      else if (!w[31])               res = fuc_pkg::SQ_POS_OFS + w;
      else                           res = fuc_pkg::SQ_NEG_OFS - {1'b0, mag};
    end else begin
      if (!w[31]) res = fuc_pkg::SIGN_BIT + w;
      else        res = fuc_pkg::SIGN_BIT - {1'b0, mag};
    end
    return res;
  endfunction

  // stage A: raw words
  logic        a_v_r, a_v_nxt;
  logic [31:0] exp_r, act_r;
  // stage B: ordered values and special-class outcome
  logic        b_v_r, b_v_nxt;
  logic [31:0] me_r, ma_r;
  logic        spec_r, spec_diff_r;
  // output stage
  logic        o_v_r, o_v_nxt;
  logic        differ_r;

  logic        o_free, b_free, a_free;
  logic        e_sp, a_sp, e_inf, a_inf, spec_diff;
  logic [32:0] d_fwd;
  logic [31:0] ulp_gap;
  logic        differ;

  assign o_free   = !o_v_r || out_ready;
  assign b_free   = !b_v_r || o_free;
  assign a_free   = !a_v_r || b_free;
  assign in_ready = a_free;

  assign a_v_nxt = a_free ? in_valid : a_v_r;
  assign b_v_nxt = b_free ? a_v_r    : b_v_r;
  assign o_v_nxt = o_free ? b_v_r    : o_v_r;

  // Special classes: exponent all ones; inf has zero fraction.
  always_comb begin
    e_sp  = exp_r[30:23] == fuc_pkg::EXP_ALL;
    a_sp  = act_r[30:23] == fuc_pkg::EXP_ALL;
    e_inf = exp_r[22:0] == 23'd0;
    a_inf = act_r[22:0] == 23'd0;
    if (!(e_sp && a_sp))      spec_diff = 1'b1;
    else if (e_inf && a_inf)  spec_diff = exp_r[31] ^ act_r[31];
    else                      spec_diff = e_inf ^ a_inf;
  end

  always_comb begin
    d_fwd   = {1'b0, me_r} - {1'b0, ma_r};
    ulp_gap = d_fwd[32] ? (ma_r - me_r) : d_fwd[31:0];
    differ  = spec_r ? spec_diff_r : (ulp_gap > {1'b0, cfg.tol});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
      o_v_r <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && in_valid) begin
      exp_r <= in_expected;
      act_r <= in_actual;
    end
    if (b_free && a_v_r) begin
      me_r        <= order_map(exp_r, cfg.squeeze);
      ma_r        <= order_map(act_r, cfg.squeeze);
      spec_r      <= e_sp || a_sp;
      spec_diff_r <= spec_diff;
    end
    if (o_free && b_v_r) begin
      differ_r <= differ;
    end
  end

  assign out_valid  = o_v_r;
  assign out_differ = differ_r;

endmodule

/* rtl/float_ulp_compare_core.sv */
// Float ULP compare core: top level.
//
// Compares two IEEE single-precision words, expected and actual, and reports
// values_differ = 1 when they differ by special class (inf/NaN rules) or when
// their ordered-integer distance exceeds ulp_tolerance. Accepts one transfer
// per clock cycle while the output is not backpressured; each result passes
// through the three register stages (input words, ordered values, result).
// Under output backpressure empty stages still fill; the input stalls once
// all three stages hold an item. Configuration registers:
// ulp_tolerance at byte address 0 (reset 2), squeeze_denormals at address 4
// (reset 0); write them only while no transfer is in flight.
module float_ulp_compare_core (
  input  logic                        clk,
  input  logic                        rst_n,
  fuc_in_if.sink                      in_ch,
  fuc_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fuc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  fuc_pkg::fuc_cfg_t cfg;

  fuc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fuc_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_expected (in_ch.expected_word),
    .in_actual   (in_ch.actual_word),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_differ  (out_ch.values_differ)
  );

endmodule

/* rtl/fuc_checker.sv */
// Port-level checks for the float ULP compare core, with bind.
`include "assert_macros.svh"

module fuc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_differ,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [fuc_pkg::ADDR_W-1:0] paddr,
  input logic [31:0]                pwdata,
  input logic [31:0]                prdata
);

  logic tol_wr;
  logic tol_rd;

  assign tol_wr = psel && penable && pwrite && (paddr[2] == fuc_pkg::REG_TOL);
  assign tol_rd = psel && !pwrite && (paddr[2] == fuc_pkg::REG_TOL);

  `FUC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)
  `FUC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_differ))
  `FUC_ASSERT(a_latency, (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready |=> out_valid)
  `FUC_ASSERT(a_tol_readback, tol_wr ##1 tol_rd |-> prdata[30:0] == $past(pwdata[30:0]))

endmodule

bind float_ulp_compare_core fuc_checker u_fuc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_differ (out_ch.values_differ),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata)
);
